// ===== rtl/fpra_pkg.sv =====
package fpra_pkg;

   localparam int unsigned SIZE_BITS        = 24;
   localparam int unsigned ID_BITS          = 32;
   localparam int unsigned POLICY_BITS      = 2;
   localparam int unsigned STATUS_BITS      = 3;

   localparam int unsigned DEF_FREE_ENTRIES = 32;
   localparam int unsigned DEF_LIVE_ENTRIES = 64;
   localparam int unsigned DEF_ADDR_BITS    = 24;

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   localparam logic [POLICY_BITS-1:0] POL_BEST  = 2'd1;
   localparam logic [POLICY_BITS-1:0] POL_WORST = 2'd2;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK           = 3'd0,
      ST_FREE_FULL    = 3'd1,
      ST_LIVE_FULL    = 3'd2,
      ST_DUP_ID       = 3'd3,
      ST_UNKNOWN_ID   = 3'd4,
      ST_MEM_EXCEEDED = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      FC_HOLD,
      FC_REMOVE,
      FC_INSERT,
      FC_SETSTART
   } fc_op_type;

   // per-cell view of a free list command
   typedef struct packed {
      fc_op_type op;
      logic      at;
      logic      above;
   } fc_ctl_type;

   typedef struct packed {
      logic set;
      logic clear;
   } lc_ctl_type;

endpackage

// ===== rtl/fpra_free_cell.sv =====
module fpra_free_cell #(
   parameter int unsigned ADDR_BITS = fpra_pkg::DEF_ADDR_BITS
) (
   input  logic                 clock,
   input  fpra_pkg::fc_ctl_type ctl,
   input  logic [ADDR_BITS-1:0] new_start,
   input  logic [ADDR_BITS:0]   new_end,
   input  logic [ADDR_BITS-1:0] left_start,
   input  logic [ADDR_BITS:0]   left_end,
   input  logic [ADDR_BITS-1:0] right_start,
   input  logic [ADDR_BITS:0]   right_end,
   output logic [ADDR_BITS-1:0] range_start,
   output logic [ADDR_BITS:0]   range_end
);
   import fpra_pkg::*;

   logic [ADDR_BITS-1:0] start_ff;
   logic [ADDR_BITS:0]   end_ff;

   always_ff @(posedge clock) begin
      unique case (ctl.op)
         FC_REMOVE: begin
            if (ctl.at || ctl.above) begin
               start_ff <= right_start;
               end_ff   <= right_end;
            end
         end
         FC_INSERT: begin
            if (ctl.at) begin
               start_ff <= new_start;
               end_ff   <= new_end;
            end else if (ctl.above) begin
               start_ff <= left_start;
               end_ff   <= left_end;
            end
         end
         FC_SETSTART: begin
            if (ctl.at) begin
               start_ff <= new_start;
            end
         end
         default: begin
         end
      endcase
   end

   assign range_start = start_ff;
   assign range_end   = end_ff;

endmodule

// ===== rtl/fpra_live_cell.sv =====
module fpra_live_cell #(
   parameter int unsigned ADDR_BITS = fpra_pkg::DEF_ADDR_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  fpra_pkg::lc_ctl_type              ctl,
   input  logic [fpra_pkg::ID_BITS-1:0]      wr_id,
   input  logic [ADDR_BITS-1:0]              wr_addr,
   input  logic [fpra_pkg::ID_BITS-1:0]      cmp_id,
   output logic                              valid,
   output logic                              match,
   output logic [ADDR_BITS-1:0]              addr
);
   import fpra_pkg::*;

   logic                 valid_ff;
   logic [ID_BITS-1:0]   id_ff;
   logic [ADDR_BITS-1:0] addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl.set) begin
         valid_ff <= 1'b1;
      end else if (ctl.clear) begin
         valid_ff <= 1'b0;
      end
      if (ctl.set) begin
         id_ff   <= wr_id;
         addr_ff <= wr_addr;
      end
   end

   assign valid = valid_ff;
   assign match = valid_ff && (id_ff == cmp_id);
   assign addr  = addr_ff;

endmodule

// ===== rtl/fit_policy_range_allocator.sv =====
// The free-list scans read one range per cycle, so the time to a result grows with the
// number of free ranges held, and a free scans the list more often than an allocate.
// One request is in work at a time. A result waiting in the output register does not
// stop the next request from being accepted, only its result load.
// Reset: policy first fit, free list empty, live table empty, peak zero.
module fit_policy_range_allocator #(
   parameter int unsigned FREE_ENTRIES = fpra_pkg::DEF_FREE_ENTRIES,
   parameter int unsigned LIVE_ENTRIES = fpra_pkg::DEF_LIVE_ENTRIES,
   parameter int unsigned ADDR_BITS    = fpra_pkg::DEF_ADDR_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [fpra_pkg::POLICY_BITS-1:0]    csr_wr_data,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_type,
   input  logic [fpra_pkg::ID_BITS-1:0]        req_tensor_id,
   input  logic [fpra_pkg::SIZE_BITS-1:0]      req_block_size,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [ADDR_BITS-1:0]                rsp_block_addr,
   output logic [ADDR_BITS:0]                  rsp_peak_usage,
   output logic [fpra_pkg::STATUS_BITS-1:0]    rsp_status
);
   import fpra_pkg::*;

   localparam int unsigned AW    = ADDR_BITS;
   localparam int unsigned PW    = ADDR_BITS + 1;
   localparam int unsigned SUM_W = ((PW > SIZE_BITS) ? PW : SIZE_BITS) + 1;
   localparam int unsigned IDX_W = $clog2(FREE_ENTRIES);
   localparam int unsigned CNT_W = $clog2(FREE_ENTRIES + 1);
   localparam logic [SUM_W-1:0] MEM_LIMIT = {{(SUM_W-1){1'b0}}, 1'b1} << AW;
   localparam logic [CNT_W-1:0] FREE_MAX  = CNT_W'(FREE_ENTRIES);

   typedef enum logic [3:0] {
      S_IDLE, S_LOOK, S_DECODE, S_BRANCH, S_ASCAN, S_AAPPLY, S_FSCAN1,
      S_FMERGE1, S_FSCAN2, S_FCHECK, S_FSCAN3, S_FREM, S_FINS, S_RESP
   } state_type;

   state_type                 state_ff;
   logic [POLICY_BITS-1:0]    policy_ff;
   logic                      type_ff;
   logic [ID_BITS-1:0]        id_ff;
   logic [SIZE_BITS-1:0]      size_ff;
   logic [LIVE_ENTRIES-1:0]   hit_ff;
   logic [LIVE_ENTRIES-1:0]   slot_ff;
   logic                      slot_any_ff;
   logic                      hit_any_ff;
   logic [AW-1:0]             addr_ff;
   logic [CNT_W-1:0]          count_ff;
   logic [PW-1:0]             peak_ff;
   logic [CNT_W-1:0]          i_ff;
   logic [IDX_W-1:0]          best_ff;
   logic                      best_found_ff;
   logic [PW-1:0]             best_len_ff;
   logic [AW-1:0]             s_ff;
   logic [PW-1:0]             e_ff;
   logic [CNT_W-1:0]          p_ff;
   logic [CNT_W-1:0]          r1_ff;
   logic [CNT_W-1:0]          r2_ff;
   logic                      r1_v_ff;
   logic                      r2_v_ff;
   logic [CNT_W-1:0]          o3_ff;
   logic [AW-1:0]             res_addr_ff;
   status_type                res_status_ff;
   logic                      rsp_valid_ff;
   logic [AW-1:0]             rsp_addr_ff;
   logic [PW-1:0]             rsp_peak_ff;
   logic [STATUS_BITS-1:0]    rsp_status_ff;

   // free list row
   logic [AW-1:0]    fs_q [FREE_ENTRIES];
   logic [PW-1:0]    fe_q [FREE_ENTRIES];
   fc_ctl_type       fc_ctl [FREE_ENTRIES];
   fc_op_type        fc_op;
   logic [CNT_W-1:0] fc_idx;
   logic [AW-1:0]    fc_new_start;

   // live table
   lc_ctl_type              lc_ctl [LIVE_ENTRIES];
   logic [LIVE_ENTRIES-1:0] live_valid;
   logic [LIVE_ENTRIES-1:0] live_match;
   logic [AW-1:0]           live_addr [LIVE_ENTRIES];
   logic [LIVE_ENTRIES-1:0] free_vec;
   logic [LIVE_ENTRIES-1:0] slot_oh;
   logic [AW-1:0]           hit_addr;
   logic                    live_set;
   logic                    live_clr;

   logic [IDX_W-1:0]  rd_idx;
   logic [AW-1:0]     rd_start;
   logic [PW-1:0]     rd_end;
   logic [PW-1:0]     rd_len;
   logic [SUM_W-1:0]  size_ext;
   logic              fits;
   logic              alloc_merge;
   logic [PW-1:0]     alloc_base;
   logic [SUM_W-1:0]  alloc_top;
   logic              alloc_over;
   logic [AW-1:0]     alloc_addr;
   logic              exact;
   logic [AW-1:0]     split_start;
   logic [SUM_W-1:0]  free_sum;
   logic [PW-1:0]     free_e;
   logic              free_nonempty;
   logic              pred;
   logic [PW-1:0]     e_max;
   logic              in_range;
   logic              skip;
   logic              pick_r1;
   logic [CNT_W-1:0]  rem_idx;
   logic              rem_any;
   logic [CNT_W-1:0]  last_cnt;
   logic [CNT_W-1:0]  p_m1;
   logic [CNT_W-1:0]  n_after;

   genvar g;
   generate
      for (g = 0; g < FREE_ENTRIES; g++) begin : g_free
         logic [AW-1:0] l_start;
         logic [PW-1:0] l_end;
         logic [AW-1:0] r_start;
         logic [PW-1:0] r_end;
         if (g == 0) begin : g_first
            assign l_start = '0;
            assign l_end   = '0;
         end else begin : g_mid
            assign l_start = fs_q[g-1];
            assign l_end   = fe_q[g-1];
         end
         if (g == FREE_ENTRIES - 1) begin : g_last
            assign r_start = fs_q[g];
            assign r_end   = fe_q[g];
         end else begin : g_inner
            assign r_start = fs_q[g+1];
            assign r_end   = fe_q[g+1];
         end
         assign fc_ctl[g].op    = fc_op;
         assign fc_ctl[g].at    = (fc_idx == CNT_W'(g));
         assign fc_ctl[g].above = (CNT_W'(g) > fc_idx);
         fpra_free_cell #(.ADDR_BITS(ADDR_BITS)) u_cell (
            .clock       (clock),
            .ctl         (fc_ctl[g]),
            .new_start   (fc_new_start),
            .new_end     (e_ff),
            .left_start  (l_start),
            .left_end    (l_end),
            .right_start (r_start),
            .right_end   (r_end),
            .range_start (fs_q[g]),
            .range_end   (fe_q[g])
         );
      end

      for (g = 0; g < LIVE_ENTRIES; g++) begin : g_live
         assign lc_ctl[g].set   = live_set && slot_ff[g];
         assign lc_ctl[g].clear = live_clr && hit_ff[g];
         fpra_live_cell #(.ADDR_BITS(ADDR_BITS)) u_cell (
            .clock   (clock),
            .reset   (reset),
            .ctl     (lc_ctl[g]),
            .wr_id   (id_ff),
            .wr_addr (alloc_addr),
            .cmp_id  (id_ff),
            .valid   (live_valid[g]),
            .match   (live_match[g]),
            .addr    (live_addr[g])
         );
      end
   endgenerate

   assign free_vec = ~live_valid;
   assign slot_oh  = free_vec & (~free_vec + LIVE_ENTRIES'(1));

   always_comb begin
      hit_addr = '0;
      for (int k = 0; k < LIVE_ENTRIES; k++) begin
         if (hit_ff[k]) begin
            hit_addr = hit_addr | live_addr[k];
         end
      end
   end

   assign last_cnt = count_ff - CNT_W'(1);
   assign p_m1     = p_ff - CNT_W'(1);

   always_comb begin
      unique case (state_ff) inside
         S_ASCAN, S_FSCAN1, S_FSCAN2, S_FSCAN3: rd_idx = i_ff[IDX_W-1:0];
         S_AAPPLY:  rd_idx = best_found_ff ? best_ff : last_cnt[IDX_W-1:0];
         S_FMERGE1: rd_idx = p_m1[IDX_W-1:0];
         default:   rd_idx = '0;
      endcase
   end

   assign rd_start    = fs_q[rd_idx];
   assign rd_end      = fe_q[rd_idx];
   assign rd_len      = rd_end - PW'(rd_start);
   assign size_ext    = SUM_W'(size_ff);
   assign fits        = SUM_W'(rd_len) >= size_ext;

   assign alloc_merge = (count_ff != '0) && (rd_end == peak_ff);
   assign alloc_base  = alloc_merge ? PW'(rd_start) : peak_ff;
   assign alloc_top   = SUM_W'(alloc_base) + size_ext;
   assign alloc_over  = alloc_top > MEM_LIMIT;
   assign alloc_addr  = best_found_ff ? rd_start : alloc_base[AW-1:0];
   assign exact       = (SUM_W'(best_len_ff) == size_ext) && (size_ff != '0);
   assign split_start = AW'(SUM_W'(rd_start) + size_ext);

   // released range is clipped at the current peak
   assign free_sum      = SUM_W'(addr_ff) + size_ext;
   assign free_e        = (free_sum > SUM_W'(peak_ff)) ? peak_ff : PW'(free_sum);
   assign free_nonempty = free_e > PW'(addr_ff);

   assign pred     = (rd_start > s_ff) || ((rd_start == s_ff) && (rd_end >= e_ff));
   assign e_max    = (rd_end > e_ff) ? rd_end : e_ff;
   assign in_range = i_ff < count_ff;
   assign skip     = (r1_v_ff && (i_ff == r1_ff)) || (r2_v_ff && (i_ff == r2_ff));

   // removals go highest index first so the other index stays put
   assign pick_r1  = r1_v_ff && (!r2_v_ff || (r1_ff >= r2_ff));
   assign rem_idx  = pick_r1 ? r1_ff : r2_ff;
   assign rem_any  = r1_v_ff || r2_v_ff;
   assign n_after  = count_ff - CNT_W'(r1_v_ff) - CNT_W'(r2_v_ff);

   always_comb begin
      fc_op        = FC_HOLD;
      fc_idx       = '0;
      fc_new_start = s_ff;
      unique case (state_ff)
         S_AAPPLY: begin
            if (best_found_ff) begin
               fc_idx       = CNT_W'(best_ff);
               fc_op        = exact ? FC_REMOVE : FC_SETSTART;
               fc_new_start = split_start;
            end
         end
         S_FREM: begin
            if (rem_any) begin
               fc_op  = FC_REMOVE;
               fc_idx = rem_idx;
            end
         end
         S_FINS: begin
            fc_op  = FC_INSERT;
            fc_idx = o3_ff;
         end
         default: begin
         end
      endcase
   end

   assign live_set = (state_ff == S_AAPPLY) && (best_found_ff || !alloc_over);
   assign live_clr = ((state_ff == S_BRANCH) && (type_ff == REQ_FREE) && hit_any_ff &&
                      !free_nonempty) || (state_ff == S_FINS);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         policy_ff    <= '0;
         count_ff     <= '0;
         peak_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            policy_ff <= csr_wr_data;
         end
         // a result load in S_RESP takes over the slot being drained
         if (rsp_valid_ff && rsp_ready && (state_ff != S_RESP)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  type_ff  <= req_type;
                  id_ff    <= req_tensor_id;
                  size_ff  <= req_block_size;
                  state_ff <= S_LOOK;
               end
            end
            S_LOOK: begin
               hit_ff      <= live_match;
               slot_ff     <= slot_oh;
               slot_any_ff <= |free_vec;
               state_ff    <= S_DECODE;
            end
            S_DECODE: begin
               hit_any_ff <= |hit_ff;
               addr_ff    <= hit_addr;
               state_ff   <= S_BRANCH;
            end
            S_BRANCH: begin
               i_ff          <= '0;
               best_found_ff <= 1'b0;
               r1_v_ff       <= 1'b0;
               r2_v_ff       <= 1'b0;
               if (type_ff == REQ_ALLOC) begin
                  if (hit_any_ff) begin
                     res_status_ff <= ST_DUP_ID;
                     res_addr_ff   <= '0;
                     state_ff      <= S_RESP;
                  end else if (!slot_any_ff) begin
                     res_status_ff <= ST_LIVE_FULL;
                     res_addr_ff   <= '0;
                     state_ff      <= S_RESP;
                  end else begin
                     state_ff <= S_ASCAN;
                  end
               end else if (!hit_any_ff) begin
                  res_status_ff <= ST_UNKNOWN_ID;
                  res_addr_ff   <= '0;
                  state_ff      <= S_RESP;
               end else begin
                  s_ff <= addr_ff;
                  e_ff <= free_e;
                  if (free_nonempty) begin
                     state_ff <= S_FSCAN1;
                  end else begin
                     res_status_ff <= ST_OK;
                     res_addr_ff   <= addr_ff;
                     state_ff      <= S_RESP;
                  end
               end
            end
            S_ASCAN: begin
               if (in_range) begin
                  if (fits && (!best_found_ff ||
                               ((policy_ff == POL_BEST) && (rd_len < best_len_ff)) ||
                               ((policy_ff == POL_WORST) && (rd_len > best_len_ff)))) begin
                     best_ff       <= i_ff[IDX_W-1:0];
                     best_len_ff   <= rd_len;
                     best_found_ff <= 1'b1;
                  end
                  i_ff <= i_ff + CNT_W'(1);
               end else begin
                  state_ff <= S_AAPPLY;
               end
            end
            S_AAPPLY: begin
               state_ff <= S_RESP;
               if (best_found_ff) begin
                  if (exact) begin
                     count_ff <= count_ff - CNT_W'(1);
                  end
                  res_status_ff <= ST_OK;
                  res_addr_ff   <= alloc_addr;
               end else if (alloc_over) begin
                  res_status_ff <= ST_MEM_EXCEEDED;
                  res_addr_ff   <= '0;
               end else begin
                  if (alloc_merge) begin
                     count_ff <= count_ff - CNT_W'(1);
                  end
                  peak_ff       <= alloc_top[PW-1:0];
                  res_status_ff <= ST_OK;
                  res_addr_ff   <= alloc_addr;
               end
            end
            S_FSCAN1: begin
               if (in_range && !pred) begin
                  i_ff <= i_ff + CNT_W'(1);
               end else begin
                  p_ff     <= i_ff;
                  state_ff <= S_FMERGE1;
               end
            end
            S_FMERGE1: begin
               if ((p_ff != '0) && (rd_end >= PW'(s_ff))) begin
                  r1_ff   <= p_m1;
                  r1_v_ff <= 1'b1;
                  s_ff    <= rd_start;
                  e_ff    <= e_max;
               end
               i_ff     <= '0;
               state_ff <= S_FSCAN2;
            end
            S_FSCAN2: begin
               if (!in_range) begin
                  state_ff <= S_FCHECK;
               end else if (skip || !pred) begin
                  i_ff <= i_ff + CNT_W'(1);
               end else begin
                  if (PW'(rd_start) <= e_ff) begin
                     e_ff    <= e_max;
                     r2_ff   <= i_ff;
                     r2_v_ff <= 1'b1;
                  end
                  state_ff <= S_FCHECK;
               end
            end
            S_FCHECK: begin
               i_ff <= '0;
               if (n_after >= FREE_MAX) begin
                  res_status_ff <= ST_FREE_FULL;
                  res_addr_ff   <= '0;
                  state_ff      <= S_RESP;
               end else begin
                  state_ff <= S_FSCAN3;
               end
            end
            S_FSCAN3: begin
               if (in_range && (skip || !pred)) begin
                  i_ff <= i_ff + CNT_W'(1);
               end else begin
                  o3_ff    <= i_ff;
                  state_ff <= S_FREM;
               end
            end
            S_FREM: begin
               if (rem_any) begin
                  if (pick_r1) begin
                     r1_v_ff <= 1'b0;
                  end else begin
                     r2_v_ff <= 1'b0;
                  end
                  count_ff <= count_ff - CNT_W'(1);
                  if (rem_idx < o3_ff) begin
                     o3_ff <= o3_ff - CNT_W'(1);
                  end
               end else begin
                  state_ff <= S_FINS;
               end
            end
            S_FINS: begin
               count_ff      <= count_ff + CNT_W'(1);
               res_status_ff <= ST_OK;
               res_addr_ff   <= addr_ff;
               state_ff      <= S_RESP;
            end
            S_RESP: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_addr_ff   <= res_addr_ff;
                  rsp_peak_ff   <= peak_ff;
                  rsp_status_ff <= res_status_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_ready      = (state_ff == S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_block_addr = rsp_addr_ff;
   assign rsp_peak_usage = rsp_peak_ff;
   assign rsp_status     = rsp_status_ff;

endmodule

// ===== verif/fit_policy_range_allocator_tb.sv =====
module fit_policy_range_allocator_tb;
   import fpra_pkg::*;

   localparam int NFREE = DEF_FREE_ENTRIES;
   localparam int NLIVE = DEF_LIVE_ENTRIES;
   localparam logic [24:0] MEM_TOP = 25'h100_0000;
   localparam logic [1:0] POL_FIRST = 2'd0;
   localparam logic [1:0] POL_ODD = 2'd3;
   localparam int STALL_LIMIT = 20000;

   typedef struct packed {
      logic [23:0] addr;
      logic [24:0] peak;
      status_type  st;
   } alloc_rsp_type;

   typedef struct {
      logic          kind;
      logic [31:0]   id;
      logic [23:0]   size;
      bit            known;
      alloc_rsp_type rsp;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [1:0]  csr_wr_data = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_type = REQ_ALLOC;
   logic [31:0] req_tensor_id = '0;
   logic [23:0] req_block_size = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [23:0] rsp_block_addr;
   logic [24:0] rsp_peak_usage;
   logic [2:0]  rsp_status;

   // allocator state as the block should hold it
   logic [24:0] fr_lo[NFREE];
   logic [24:0] fr_hi[NFREE];
   int          fr_n;
   logic [24:0] peak_now;
   logic [31:0] lv_id[NLIVE];
   logic [23:0] lv_addr[NLIVE];
   bit          lv_on[NLIVE];
   logic [1:0]  policy;
   int unsigned size_of[int unsigned];

   alloc_rsp_type pending_rsp[$];
   int          errors = 0;
   int          beats_in = 0, beats_out = 0;
   int          stat_seen[8];
   bit          no_idle = 0;
   bit          hold_req = 0;
   int          hold_left = 0;
   int          idle_cycles = 0;

   fit_policy_range_allocator i_dut (
      .clock, .reset, .csr_wr_en, .csr_wr_data,
      .req_valid, .req_ready, .req_type, .req_tensor_id, .req_block_size,
      .rsp_valid, .rsp_ready, .rsp_block_addr, .rsp_peak_usage, .rsp_status
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int find_id(logic [31:0] id);
      for (int i = 0; i < NLIVE; i++)
         if (lv_on[i] && lv_id[i] == id) return i;
      return -1;
   endfunction

   function automatic int pick_range(logic [24:0] size);
      int best;
      logic [24:0] best_len, len;
      best = -1;
      best_len = '0;
      for (int i = 0; i < fr_n; i++) begin
         len = fr_hi[i] - fr_lo[i];
         if (len < size) continue;
         if (best < 0) begin
            best = i;
            best_len = len;
            if (policy != POL_BEST && policy != POL_WORST) break;
         end else if ((policy == POL_BEST && len < best_len) ||
                      (policy == POL_WORST && len > best_len)) begin
            best = i;
            best_len = len;
         end
      end
      return best;
   endfunction

   function automatic int order_pos(logic [24:0] cs[NFREE], logic [24:0] ce[NFREE],
                                    int n, logic [24:0] s, logic [24:0] e);
      int i;
      for (i = 0; i < n; i++)
         if (cs[i] > s || (cs[i] == s && ce[i] >= e)) break;
      return i;
   endfunction

   function automatic alloc_rsp_type calc_alloc(logic [31:0] id, logic [23:0] size);
      alloc_rsp_type r;
      int slot, idx;
      bit merge;
      logic [24:0] base, top, a;
      r = '{addr: '0, peak: '0, st: ST_OK};
      slot = -1;
      if (find_id(id) >= 0) r.st = ST_DUP_ID;
      else begin
         for (int i = 0; i < NLIVE; i++)
            if (!lv_on[i]) begin slot = i; break; end
         if (slot < 0) r.st = ST_LIVE_FULL;
      end
      if (r.st == ST_OK) begin
         idx = pick_range({1'b0, size});
         if (idx < 0) begin
            merge = fr_n > 0 && fr_hi[fr_n-1] == peak_now;
            base = merge ? fr_lo[fr_n-1] : peak_now;
            top = base + size;
            if (top > MEM_TOP) r.st = ST_MEM_EXCEEDED;
            else begin
               if (merge) fr_n--;
               peak_now = top;
               a = base;
            end
         end else begin
            a = fr_lo[idx];
            if (fr_hi[idx] - fr_lo[idx] == size && size != 0) begin
               for (int i = idx; i + 1 < fr_n; i++) begin
                  fr_lo[i] = fr_lo[i+1];
                  fr_hi[i] = fr_hi[i+1];
               end
               fr_n--;
            end else fr_lo[idx] = fr_lo[idx] + size;
         end
         if (r.st == ST_OK) begin
            lv_on[slot] = 1;
            lv_id[slot] = id;
            lv_addr[slot] = a[23:0];
            r.addr = a[23:0];
         end
      end
      r.peak = peak_now;
      return r;
   endfunction

   function automatic alloc_rsp_type calc_release(logic [31:0] id, logic [23:0] size);
      alloc_rsp_type r;
      logic [24:0] cs[NFREE], ce[NFREE], s, e;
      int n, p, slot;
      r = '{addr: '0, peak: '0, st: ST_OK};
      slot = find_id(id);
      if (slot < 0) r.st = ST_UNKNOWN_ID;
      else begin
         s = lv_addr[slot];
         e = s + size;
         if (e > peak_now) e = peak_now;
         r.addr = s[23:0];
         if (e > s) begin
            cs = fr_lo;
            ce = fr_hi;
            n = fr_n;
            p = order_pos(cs, ce, n, s, e);
            if (p > 0 && ce[p-1] >= s) begin
               s = cs[p-1];
               if (ce[p-1] > e) e = ce[p-1];
               for (int i = p - 1; i + 1 < n; i++) begin
                  cs[i] = cs[i+1];
                  ce[i] = ce[i+1];
               end
               n--;
            end
            p = order_pos(cs, ce, n, s, e);
            if (p < n && cs[p] <= e) begin
               if (ce[p] > e) e = ce[p];
               for (int i = p; i + 1 < n; i++) begin
                  cs[i] = cs[i+1];
                  ce[i] = ce[i+1];
               end
               n--;
            end
            if (n >= NFREE) r.st = ST_FREE_FULL;
            else begin
               p = order_pos(cs, ce, n, s, e);
               for (int i = n; i > p; i--) begin
                  cs[i] = cs[i-1];
                  ce[i] = ce[i-1];
               end
               cs[p] = s;
               ce[p] = e;
               fr_lo = cs;
               fr_hi = ce;
               fr_n = n + 1;
            end
         end
         if (r.st == ST_OK) lv_on[slot] = 0;
      end
      if (r.st != ST_OK) r.addr = '0;
      r.peak = peak_now;
      return r;
   endfunction

   // drive one request; table rows may carry their own expectation
   task automatic send(logic kind, logic [31:0] id, logic [23:0] size,
                       bit known = 0, alloc_rsp_type want = '0);
      alloc_rsp_type r;
      if (!no_idle && $urandom_range(99) < 13) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_tensor_id <= id;
      req_block_size <= size;
      do @(posedge clock); while (!req_ready);
      r = (kind == REQ_ALLOC) ? calc_alloc(id, size) : calc_release(id, size);
      if (kind == REQ_ALLOC && r.st == ST_OK) size_of[id] = size;
      pending_rsp = {pending_rsp, (known ? want : r)};
      beats_in++;
   endtask

   task automatic drain_and_set(logic [1:0] pol);
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (120) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= pol;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      policy = pol;
   endtask

   task automatic random_item(int alloc_pct);
      int slot, cnt;
      logic [31:0] id;
      logic [23:0] size;
      int unsigned roll;
      roll = $urandom_range(99);
      size = ($urandom_range(19) == 0) ? 24'($urandom) : 24'($urandom_range(0, 300));
      if (roll < alloc_pct) begin
         id = $urandom_range(0, 4000);
         if ($urandom_range(29) == 0) id = $urandom;
         send(REQ_ALLOC, id, size);
      end else if (roll < 93) begin
         cnt = 0;
         slot = -1;
         for (int i = 0; i < NLIVE; i++)
            if (lv_on[i] && $urandom_range(cnt) == 0) begin
               slot = i;
               cnt++;
            end
         if (slot < 0) send(REQ_FREE, $urandom, size);
         else begin
            id = lv_id[slot];
            if (size_of.exists(id) && $urandom_range(9) != 0) size = size_of[id];
            send(REQ_FREE, id, size);
         end
      end else begin
         // noise: frees and allocates with random ids, mostly unknown to the live table
         send(roll[0] ? REQ_FREE : REQ_ALLOC, $urandom, size);
      end
   endtask

   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_req) begin
         rsp_ready <= 1'b0;
         hold_left <= 400;
         hold_req <= 1'b0;
      end else begin
         rsp_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 13);
      end
   end

   always @(posedge clock) begin
      alloc_rsp_type w;
      if (!reset && rsp_valid && rsp_ready) begin
         beats_out++;
         stat_seen[rsp_status]++;
         if (pending_rsp.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected beat: addr %h peak %h status %0d",
                                       rsp_block_addr, rsp_peak_usage, rsp_status);
         end else begin
            w = pending_rsp.pop_front();
            if (rsp_block_addr !== w.addr || rsp_peak_usage !== w.peak ||
                rsp_status !== w.st) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch: exp addr %h peak %h status %0d, got %h %h %0d",
                           w.addr, w.peak, w.st, rsp_block_addr, rsp_peak_usage,
                           rsp_status);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   stim_row_type rows[$];

   initial begin
      for (int i = 0; i < NLIVE; i++) lv_on[i] = 0;
      fr_n = 0;
      peak_now = '0;
      policy = POL_FIRST;
      for (int i = 0; i < 8; i++) stat_seen[i] = 0;
      rows = '{
         '{REQ_ALLOC, 32'd1, 24'd16, 1, '{24'd0, 25'd16, ST_OK}},
         '{REQ_ALLOC, 32'd1, 24'd5, 1, '{24'd0, 25'd16, ST_DUP_ID}},
         '{REQ_FREE, 32'd99, 24'd5, 1, '{24'd0, 25'd16, ST_UNKNOWN_ID}},
         '{REQ_ALLOC, 32'd2, 24'hFFFFFF, 1, '{24'd0, 25'd16, ST_MEM_EXCEEDED}},
         '{REQ_ALLOC, 32'd3, 24'd0, 1, '{24'd16, 25'd16, ST_OK}},
         '{REQ_FREE, 32'd3, 24'd0, 1, '{24'd16, 25'd16, ST_OK}},
         '{REQ_FREE, 32'd1, 24'd16, 1, '{24'd0, 25'd16, ST_OK}},
         '{REQ_ALLOC, 32'hFFFFFFFF, 24'hFFFFFF, 1, '{24'd0, 25'hFFFFFF, ST_OK}},
         '{REQ_ALLOC, 32'd0, 24'd1, 1, '{24'hFFFFFF, 25'h1000000, ST_OK}},
         '{REQ_ALLOC, 32'd7, 24'd0, 1, '{24'd0, 25'h1000000, ST_OK}},
         '{REQ_FREE, 32'hFFFFFFFF, 24'd32, '0, '0},
         '{REQ_ALLOC, 32'd8, 24'd10, '0, '0},
         '{REQ_FREE, 32'd0, 24'hFFFFFF, '0, '0},
         '{REQ_FREE, 32'd7, 24'hAAAAAA, '0, '0},
         '{REQ_FREE, 32'd8, 24'h555555, '0, '0},
         '{REQ_ALLOC, 32'h5555AAAA, 24'd40, '0, '0},
         '{REQ_FREE, 32'h5555AAAA, 24'd40, '0, '0}
      };
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      drain_and_set(POL_FIRST);
      foreach (rows[i]) send(rows[i].kind, rows[i].id, rows[i].size, rows[i].known,
                             rows[i].rsp);
      // fill the live table, punch alternate holes, then force a list overflow
      for (int i = 0; i < NLIVE + 2; i++) send(REQ_ALLOC, 32'd5000 + i, 24'd8);
      for (int i = 0; i < NLIVE; i += 2) send(REQ_FREE, 32'd5000 + i, 24'd8);
      send(REQ_ALLOC, 32'd6000, 24'd4);
      send(REQ_ALLOC, 32'd6001, 24'd2);
      send(REQ_FREE, 32'd6000, 24'd4);
      send(REQ_FREE, 32'd6001, 24'd2);
      for (int i = 1; i < NLIVE; i += 2) send(REQ_FREE, 32'd5000 + i, 24'd8);
      send(REQ_FREE, 32'd6000, 24'd4);
      foreach (lv_on[i]) if (lv_on[i]) send(REQ_FREE, lv_id[i], 24'hFFFFFF);
      for (int ph = 0; ph < 8; ph++) begin
         drain_and_set(ph == 7 ? POL_ODD : 2'(ph % 3));
         no_idle = (ph == 2);
         for (int k = 0; k < 165; k++) begin
            if (ph == 1 && k == 60) hold_req = 1'b1;
            random_item(ph % 2 ? 55 : 70);
         end
      end
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
      $display("requests %0d, results %0d; status counts ok %0d free-full %0d live-full %0d",
               beats_in, beats_out, stat_seen[ST_OK], stat_seen[ST_FREE_FULL],
               stat_seen[ST_LIVE_FULL]);
      $display("dup-id %0d unknown-id %0d mem-exceeded %0d, all four policies used",
               stat_seen[ST_DUP_ID], stat_seen[ST_UNKNOWN_ID], stat_seen[ST_MEM_EXCEEDED]);
      if (errors == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

endmodule
